>>> sv/sign_magnitude_pcm_upsampler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sign-magnitude PCM upsampler
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SIGN_MAGNITUDE_PCM_UPSAMPLER_DEFINES_SVH
`define SIGN_MAGNITUDE_PCM_UPSAMPLER_DEFINES_SVH

// same-cycle implication
`define SMPU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define SMPU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/smpu_pkg.sv
// ----------------------------------------------------------------------------
// smpu_pkg
// Types and constants shared by the front, queue and back of the upsampler.
// ----------------------------------------------------------------------------
package smpu_pkg;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTRW  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNTW  = $clog2(QDEPTH + 1);

	// interpolation divide: sample = trunc(32*x/125), x = 666a+333b on 7-bit codes
	localparam int MW          = 22;                 // |32x| magnitude width
	localparam int RECIPW      = 23;
	localparam int RECIP_SHIFT = 29;
	localparam logic [RECIPW-1:0] RECIP = RECIPW'((64'd1 << RECIP_SHIFT) / 125);
	localparam logic [MW-1:0]     DIVISOR = MW'(125);
	localparam int PRODW       = MW + RECIPW;
	localparam int REMW        = 8;                  // remainder stays below 250

	// one classified code waiting for the back end
	typedef struct packed {
		logic [7:0] prev_val;  // previous code value, two's complement, -127..127
		logic [7:0] cur_val;   // current code value
		logic       has_prev;
		logic       avg;       // phase 3: single midpoint
		logic       last;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [2:0] {
		K_PREV,
		K_AVG,
		K_I1,
		K_I2,
		K_CUR
	} step_kind_t;

	typedef struct packed {
		logic valid;
		logic interp;
		logic neg;
		logic run_end;
		logic stream_end;
	} ctrl_t;

endpackage

>>> sv/sign_magnitude_pcm_upsampler.sv
// ----------------------------------------------------------------------------
// sign_magnitude_pcm_upsampler
// 11/4 linear-interpolation upsampler for 8-bit sign-magnitude audio codes.
// ----------------------------------------------------------------------------
// Path: an accepted code is queued, then its results pass the back-end pipe registers.
// Throughput: one result per cycle while out_ready does not stall the output; a code
//   makes from 0 results (an opening code) up to 4, 2.75 on average on a steady stream.
// Input ready drops only while the two-entry queue is full.
// Reset: arst_n clears sample, phase, queue and pipeline valids; output idle.
module sign_magnitude_pcm_upsampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  raw_code,
	input  logic        final_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] pcm_sample,
	output logic        run_end,
	output logic        stream_end
);

`include "sign_magnitude_pcm_upsampler_defines.svh"

	smpu_pkg::entry_t  push_entry;
	smpu_pkg::entry_t  head;
	smpu_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;
	logic [15:0]       sample;

	smpu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_code   (raw_code),
		.final_code (final_code),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	smpu_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	smpu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pcm_sample (sample),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

	assign pcm_sample = $signed(sample);

	`SMPU_ASSERT_NOW(a_stream_end_closes_run, out_valid && stream_end, run_end)
	`SMPU_ASSERT_NOW(a_pop_needs_entry, pop, !q_stat.empty)
	`SMPU_ASSERT_NOW(a_queue_state_sane, 1'b1, !(q_stat.full && q_stat.empty))
	`SMPU_ASSERT_NEXT(a_push_fills_queue, push && !pop, !q_stat.empty)

endmodule

>>> sv/smpu_front.sv
// ----------------------------------------------------------------------------
// smpu_front
// Accepts codes, decodes sign-magnitude, tracks previous sample and phase,
// and pushes one classified entry per code that produces output.
// ----------------------------------------------------------------------------
module smpu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       raw_code,
	input  logic             final_code,
	input  smpu_pkg::q_stat_t q_stat,
	output logic             push,
	output smpu_pkg::entry_t push_entry
);

	logic [7:0] prev_q;
	logic       have_prev_q;
	logic [1:0] phase_q;
	logic [7:0] mag;
	logic [7:0] cur_val;
	logic       accept;

	assign mag     = {1'b0, raw_code[6:0]};
	// minus zero decodes to zero through the negate
	assign cur_val = raw_code[7] ? (~mag + 8'd1) : mag;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// the first code of a stream that is not final emits nothing
	assign push = accept && (have_prev_q || final_code);

	always_comb begin
		push_entry.prev_val = prev_q;
		push_entry.cur_val  = cur_val;
		push_entry.has_prev = have_prev_q;
		push_entry.avg      = (phase_q == 2'd3);
		push_entry.last     = final_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			phase_q     <= '0;
		end else if (accept) begin
			if (final_code) begin
				prev_q      <= '0;
				have_prev_q <= 1'b0;
				phase_q     <= '0;
			end else begin
				prev_q      <= cur_val;
				have_prev_q <= 1'b1;
				phase_q     <= phase_q + 2'd1;
			end
		end
	end

endmodule

>>> sv/smpu_fifo.sv
// ----------------------------------------------------------------------------
// smpu_fifo
// Short entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module smpu_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  smpu_pkg::entry_t  push_entry,
	input  logic              pop,
	output smpu_pkg::entry_t  head,
	output smpu_pkg::q_stat_t q_stat
);

	smpu_pkg::entry_t              mem_q [smpu_pkg::QDEPTH];
	logic [smpu_pkg::QPTRW-1:0]    wr_ptr_q;
	logic [smpu_pkg::QPTRW-1:0]    rd_ptr_q;
	logic [smpu_pkg::QCNTW-1:0]    count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == smpu_pkg::QCNTW'(smpu_pkg::QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == smpu_pkg::QPTRW'(smpu_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + smpu_pkg::QPTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == smpu_pkg::QPTRW'(smpu_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + smpu_pkg::QPTRW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + smpu_pkg::QCNTW'(1);
				2'b01:   count_q <= count_q - smpu_pkg::QCNTW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/smpu_back.sv
// ----------------------------------------------------------------------------
// smpu_back
// Steps through the results of the head entry, one per cycle while the pipe advances,
// into a four-stage arithmetic pipe: mix, reciprocal multiply, remainder, output.
// ----------------------------------------------------------------------------
module smpu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  smpu_pkg::entry_t  head,
	input  smpu_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       pcm_sample,
	output logic              run_end,
	output logic              stream_end
);

	logic [1:0]                    step_q;
	smpu_pkg::step_kind_t          kind;
	logic [2:0]                    n_steps;
	logic                          last_step;
	logic                          adv;
	logic                          issue;

	logic [7:0]                    c_hi;
	logic [7:0]                    c_lo;
	logic signed [17:0]            mix;
	logic [17:0]                   mix_abs;
	logic [8:0]                    pair_sum;
	logic [15:0]                   direct;

	smpu_pkg::ctrl_t               ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	logic [smpu_pkg::MW-1:0]       m_s1, m_s2;
	logic [15:0]                   direct_s1, direct_s2, direct_s3;
	logic [smpu_pkg::PRODW-1:0]    prod_s2;
	logic [15:0]                   q0;
	logic [smpu_pkg::MW-1:0]       rem_full;
	logic [15:0]                   q0_s3;
	logic [smpu_pkg::REMW-1:0]     rem_s3;
	logic [15:0]                   quot;
	logic [15:0]                   sample_s4;

	// whole pipe moves together; the output stage is the skid point
	assign adv   = !ctrl_s4.valid || out_ready;
	assign issue = adv && !q_stat.empty;

	always_comb begin
		case (step_q)
			2'd0:    kind = head.has_prev ? smpu_pkg::K_PREV : smpu_pkg::K_CUR;
			2'd1:    kind = head.avg ? smpu_pkg::K_AVG : smpu_pkg::K_I1;
			2'd2:    kind = head.avg ? smpu_pkg::K_CUR : smpu_pkg::K_I2;
			default: kind = smpu_pkg::K_CUR;
		endcase
	end

	// entries without a previous sample are always final
	assign n_steps   = head.has_prev ? ((head.avg ? 3'd2 : 3'd3) + {2'b00, head.last}) : 3'd1;
	assign last_step = ({1'b0, step_q} == (n_steps - 3'd1));
	assign pop       = issue && last_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (issue) begin
			step_q <= last_step ? 2'd0 : step_q + 2'd1;
		end
	end

	// mix: 666*hi + 333*lo on the 7-bit code values (samples are codes * 256)
	assign c_hi    = (kind == smpu_pkg::K_I2) ? head.cur_val : head.prev_val;
	assign c_lo    = (kind == smpu_pkg::K_I2) ? head.prev_val : head.cur_val;
	assign mix     = $signed({{10{c_hi[7]}}, c_hi}) * 18'sd666
	               + $signed({{10{c_lo[7]}}, c_lo}) * 18'sd333;
	assign mix_abs = mix[17] ? (~mix + 18'd1) : mix;
	assign pair_sum = {head.prev_val[7], head.prev_val} + {head.cur_val[7], head.cur_val};

	always_comb begin
		case (kind)
			smpu_pkg::K_PREV: direct = {head.prev_val, 8'd0};
			smpu_pkg::K_AVG:  direct = {pair_sum, 7'd0};
			smpu_pkg::K_CUR:  direct = {head.cur_val, 8'd0};
			default:          direct = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else if (adv) begin
			ctrl_s1.valid      <= issue;
			ctrl_s1.interp     <= (kind == smpu_pkg::K_I1) || (kind == smpu_pkg::K_I2);
			ctrl_s1.neg        <= mix[17];
			ctrl_s1.run_end    <= last_step;
			ctrl_s1.stream_end <= (kind == smpu_pkg::K_CUR);
			ctrl_s2            <= ctrl_s1;
			ctrl_s3            <= ctrl_s2;
			ctrl_s4            <= ctrl_s3;
		end
	end

	// divide by 125: truncated reciprocal estimate is exact or one short
	assign q0       = prod_s2[smpu_pkg::RECIP_SHIFT+15:smpu_pkg::RECIP_SHIFT];
	assign rem_full = m_s2 - smpu_pkg::MW'(q0) * smpu_pkg::DIVISOR;
	assign quot     = q0_s3 + {15'd0, (rem_s3 >= smpu_pkg::REMW'(125))};

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1      <= {mix_abs[16:0], 5'd0};
			direct_s1 <= direct;
			m_s2      <= m_s1;
			prod_s2   <= smpu_pkg::PRODW'(m_s1) * smpu_pkg::PRODW'(smpu_pkg::RECIP);
			direct_s2 <= direct_s1;
			q0_s3     <= q0;
			rem_s3    <= rem_full[smpu_pkg::REMW-1:0];
			direct_s3 <= direct_s2;
			if (ctrl_s3.interp) begin
				sample_s4 <= ctrl_s3.neg ? (~quot + 16'd1) : quot;
			end else begin
				sample_s4 <= direct_s3;
			end
		end
	end

	assign out_valid  = ctrl_s4.valid;
	assign pcm_sample = sample_s4;
	assign run_end    = ctrl_s4.run_end;
	assign stream_end = ctrl_s4.stream_end;

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: sign_magnitude_pcm_upsampler regression
// Drives sign-magnitude code streams through valid/ready with random gaps on
// both sides and one long output stall. Each result beat is checked against
// an in-bench 11/4 linear-interpolation model of the same stream.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_CYCLES = 2000;
	localparam int RANDOM_CODES    = 330;
	localparam int HOLD_CYCLES     = 300;
	localparam int MAX_REPORTS     = 10;
	localparam int DRAIN_CYCLES    = 16;

	typedef struct {
		logic [7:0] code;
		logic       fin;
	} code_beat_t;

	typedef struct {
		logic signed [15:0] smp;
		logic               run_end;
		logic               stream_end;
	} pcm_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] raw_code = 8'h00;
	logic final_code = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] pcm_sample;
	logic run_end;
	logic stream_end;

	code_beat_t code_q[$];
	pcm_exp_t   pcm_expect_q[$];

	// stream model state
	logic signed [15:0] prev_smp = '0;
	logic               have_prev = 1'b0;
	logic [1:0]         ph = 2'd0;

	logic in_took = 1'b0;
	logic out_took = 1'b0;
	logic hold_rx = 1'b0;
	int   idle_cycles = 0;
	int   err_count = 0;
	int   results_seen = 0;
	int   tx_gap = 0;
	int   tx_run = 0;
	bit   tx_steady = 1'b0;
	int   rx_gap = 0;
	int   rx_run = 0;
	bit   rx_steady = 1'b0;
	code_beat_t next_beat;
	pcm_exp_t   head_exp;

	sign_magnitude_pcm_upsampler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.raw_code  (raw_code),
		.final_code(final_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pcm_sample(pcm_sample),
		.run_end   (run_end),
		.stream_end(stream_end)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic queue_code(input logic [7:0] code, input logic fin);
		code_beat_t b;
		b.code = code;
		b.fin  = fin;
		code_q.insert(code_q.size(), b);
	endtask

	// Expected output samples for one accepted code
	task automatic upsample_code(input logic [7:0] code, input logic fin);
		int vals[4];
		int n;
		int s;
		int p;
		pcm_exp_t e;
		n = 0;
		s = int'(code[6:0]) * 256;
		if (code[7])
			s = -s;
		if (have_prev) begin
			p = int'(prev_smp);
			vals[n] = p;
			n++;
			if (ph == 2'd3) begin
				vals[n] = (p + s) / 2;
				n++;
			end else begin
				vals[n] = (666 * p + 333 * s) / 1000;
				n++;
				vals[n] = (333 * p + 666 * s) / 1000;
				n++;
			end
		end
		prev_smp = 16'(s);
		have_prev = 1'b1;
		ph = ph + 2'd1;
		if (fin) begin
			vals[n] = s;
			n++;
			// stream closes: back to the reset state
			prev_smp = '0;
			have_prev = 1'b0;
			ph = 2'd0;
		end
		for (int i = 0; i < n; i++) begin
			e.smp        = 16'(vals[i]);
			e.run_end    = (i == n - 1);
			e.stream_end = fin && (i == n - 1);
			pcm_expect_q.insert(pcm_expect_q.size(), e);
		end
	endtask

	// sender: new beats at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_took) begin
				if (tx_run == 0) begin
					tx_run = $urandom_range(8, 40);
					tx_steady = ($urandom_range(0, 2) == 0);
				end
				tx_run--;
				tx_gap = tx_steady ? 0 : $urandom_range(0, 14);
			end
			if (!in_valid || in_took) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (code_q.size() > 0) begin
					next_beat = code_q[0];
					code_q.delete(0);
					in_valid <= 1'b1;
					raw_code <= next_beat.code;
					final_code <= next_beat.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: ready at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_took) begin
				if (rx_run == 0) begin
					rx_run = $urandom_range(8, 40);
					rx_steady = ($urandom_range(0, 2) == 0);
				end
				rx_run--;
				rx_gap = rx_steady ? 0 : $urandom_range(0, 14);
			end
			if (hold_rx) begin
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long output stall so the input side backs up
	initial begin
		wait (results_seen >= 40);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// monitor: both handshakes sampled at the rising edge
	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		out_took <= out_valid && out_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				upsample_code(raw_code, final_code);
			if (out_valid && out_ready) begin
				results_seen++;
				if (pcm_expect_q.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("unexpected beat: sample %0d run_end %0b stream_end %0b",
							pcm_sample, run_end, stream_end);
				end else begin
					head_exp = pcm_expect_q[0];
					pcm_expect_q.delete(0);
					if (pcm_sample !== head_exp.smp || run_end !== head_exp.run_end ||
							stream_end !== head_exp.stream_end) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
								head_exp.smp, head_exp.run_end, head_exp.stream_end,
								pcm_sample, run_end, stream_end);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n_rand;
		int len;
		logic [7:0] c;

		// single-code streams, one with minus zero
		queue_code(8'h7F, 1'b1);
		queue_code(8'h80, 1'b1);
		// extremes, walking through every phase
		queue_code(8'h7F, 1'b0);
		queue_code(8'hFF, 1'b0);
		queue_code(8'h00, 1'b0);
		queue_code(8'h80, 1'b0);
		queue_code(8'h01, 1'b0);
		queue_code(8'h81, 1'b0);
		queue_code(8'h40, 1'b0);
		queue_code(8'hC0, 1'b1);
		// two-code stream
		queue_code(8'hFF, 1'b0);
		queue_code(8'h7F, 1'b1);
		// closes on the midpoint phase
		queue_code(8'h12, 1'b0);
		queue_code(8'h93, 1'b0);
		queue_code(8'h7F, 1'b0);
		queue_code(8'hFF, 1'b1);
		// closes one code into the next cycle of phases
		queue_code(8'hAA, 1'b0);
		queue_code(8'h55, 1'b0);
		queue_code(8'hFF, 1'b0);
		queue_code(8'hFF, 1'b0);
		queue_code(8'h7F, 1'b1);

		n_rand = 0;
		while (n_rand < RANDOM_CODES) begin
			len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
			for (int k = 0; k < len; k++) begin
				c = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 15) == 0)
					c = {1'($urandom_range(0, 1)), ($urandom_range(0, 1) ? 7'h7F : 7'h00)};
				queue_code(c, k == len - 1);
			end
			n_rand += len;
		end

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		while (!(code_q.size() == 0 && !in_valid && pcm_expect_q.size() == 0) &&
				idle_cycles < WATCHDOG_CYCLES)
			@(posedge clk);

		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("sign_magnitude_pcm_upsampler regression: fail");
		end else begin
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (err_count == 0 && pcm_expect_q.size() == 0)
				$display("sign_magnitude_pcm_upsampler regression: pass");
			else
				$display("sign_magnitude_pcm_upsampler regression: fail");
		end
		$finish;
	end
endmodule
